@@ rtl/wsm_pkg.sv @@
// Shared types and constants for the wildcard sequence matcher.
package wsm_pkg;

    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int ERR_W      = 2;
    localparam int ID_FIELD_W = 16;

    // s_tdata layout
    localparam int S_ELEM_LSB = 0;
    localparam int S_KIND_LSB = S_ELEM_LSB + ID_FIELD_W;
    localparam int S_MID_LSB  = S_KIND_LSB + KIND_W;
    localparam int S_BU_BIT   = S_MID_LSB + ID_FIELD_W;
    localparam int S_DATA_W   = ((S_BU_BIT + 1 + 7) / 8) * 8;

    // m_tdata layout
    localparam int M_HIT_BIT  = 0;
    localparam int M_ERR_LSB  = 1;
    localparam int M_DATA_W   = 8;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ANY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ID   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_REST = 2'd1;
    localparam logic [ERR_W-1:0] ERR_KIND = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVF  = 2'd3;

    // Comparison flags fed to the step decision
    typedef struct packed {
        logic              skip;     // searching for the matcher after a REST
        logic              p_lt_n;   // elements remain
        logic              m_eq_pc;  // pattern exhausted
        logic              m_last;   // current matcher is the last one
        logic              id_eq;    // element ID equals matcher ID
        logic [KIND_W-1:0] kind;
    } step_in_t;

    // Outcome of one scan step
    typedef struct packed {
        logic             done;
        logic             hit;
        logic [ERR_W-1:0] err;
        logic             inc_p;
        logic             inc_m;
        logic             skip_next;
    } step_t;

endpackage

@@ rtl/wsm_step.sv @@
// One step of the greedy pattern scan: decides advance, finish and error.
module wsm_step import wsm_pkg::*; (
    input  step_in_t si,
    output step_t    so
);

    always_comb begin
        so.done      = 1'b0;
        so.hit       = 1'b0;
        so.err       = ERR_NONE;
        so.inc_p     = 1'b0;
        so.inc_m     = 1'b0;
        so.skip_next = si.skip;
        if (!si.skip) begin
            if (si.m_eq_pc) begin
                so.done = 1'b1;
                so.hit  = 1'b1;
            end else begin
                unique case (si.kind)
                    KIND_ANY: begin
                        if (!si.p_lt_n) begin
                            so.done = 1'b1;
                        end else begin
                            so.inc_p = 1'b1;
                            so.inc_m = 1'b1;
                        end
                    end
                    KIND_ID: begin
                        if (!si.p_lt_n || !si.id_eq) begin
                            so.done = 1'b1;
                        end else begin
                            so.inc_p = 1'b1;
                            so.inc_m = 1'b1;
                        end
                    end
                    KIND_REST: begin
                        if (si.m_last) begin
                            so.done = 1'b1;
                            so.hit  = 1'b1;
                        end else begin
                            so.inc_m     = 1'b1;
                            so.skip_next = 1'b1;
                        end
                    end
                    KIND_BAD: begin
                        so.done = 1'b1;
                        so.err  = ERR_KIND;
                    end
                endcase
            end
        end else begin
            // skip-ahead: unsupported kind here is compared by ID
            priority if (!si.p_lt_n) begin
                so.done = 1'b1;
            end else if (si.kind == KIND_REST) begin
                so.done = 1'b1;
                so.err  = ERR_REST;
            end else if (si.kind == KIND_ANY || si.id_eq) begin
                so.inc_p     = 1'b1;
                so.inc_m     = 1'b1;
                so.skip_next = 1'b0;
            end else begin
                so.inc_p = 1'b1;
            end
        end
    end

endmodule

@@ rtl/wildcard_sequence_matcher.sv @@
// Top level of the wildcard sequence matcher: stores, scan sequencer and stream ports.
//
// Push and append transactions are taken one per cycle and give no result. An evaluate
// transaction scans the element and pattern memories, both with registered reads; each
// scan step is a read state followed by a decide state, and a scan takes at most about
// stack depth plus pattern length plus one steps, then the output state hands the verdict
// on once the output register can take it. After a store overflow the evaluation goes
// straight to the output state, without a scan. New transactions are taken again as soon
// as the verdict sits in the output register, and every evaluation empties both stores.
module wildcard_sequence_matcher import wsm_pkg::*; #(
    parameter int MAX_ELEMENTS = 64,
    parameter int MAX_MATCHERS = 16,
    parameter int ID_BITS      = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // element_id[15:0], matcher_kind[17:16], matcher_id[33:18], bottom_up[34], zero
    input  logic [S_DATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]    s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // matched[0], error_code[2:1], zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int IW  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
    localparam int EAW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int PAW = (MAX_MATCHERS > 1) ? $clog2(MAX_MATCHERS) : 1;
    localparam int ECW = $clog2(MAX_ELEMENTS + 1);
    localparam int PCW = $clog2(MAX_MATCHERS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_EX   = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [ECW-1:0]   elem_cnt_reg, elem_cnt_next;
    logic [PCW-1:0]   pat_cnt_reg, pat_cnt_next;
    logic             ovf_reg, ovf_next;
    logic [ECW-1:0]   p_reg, p_next;
    logic [PCW-1:0]   m_reg, m_next;
    logic             skip_reg, skip_next;
    logic             bu_reg, bu_next;
    logic             res_hit_reg, res_hit_next;
    logic [ERR_W-1:0] res_err_reg, res_err_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_hit_reg, out_hit_next;
    logic [ERR_W-1:0] out_err_reg, out_err_next;

    logic [IW-1:0]        elem_mem [MAX_ELEMENTS];
    logic [KIND_W+IW-1:0] pat_mem  [MAX_MATCHERS];
    logic [IW-1:0]        elem_rd_reg;
    logic [KIND_W+IW-1:0] pat_rd_reg;

    logic [CMD_W-1:0]      s_command;
    logic [ID_FIELD_W-1:0] s_element_id;
    logic [KIND_W-1:0]     s_matcher_kind;
    logic [ID_FIELD_W-1:0] s_matcher_id;
    logic                  s_bottom_up;

    logic           s_acc;
    logic           elem_full, pat_full;
    logic           load_elem, load_pat;
    logic [ECW-1:0] top_pos;
    logic [EAW-1:0] elem_raddr;
    logic [PAW-1:0] pat_raddr;
    step_in_t       step_in;
    step_t          step;

    assign s_command      = s_tuser;
    assign s_element_id   = s_tdata[S_ELEM_LSB +: ID_FIELD_W];
    assign s_matcher_kind = s_tdata[S_KIND_LSB +: KIND_W];
    assign s_matcher_id   = s_tdata[S_MID_LSB +: ID_FIELD_W];
    assign s_bottom_up    = s_tdata[S_BU_BIT];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign elem_full = (elem_cnt_reg == ECW'(MAX_ELEMENTS));
    assign pat_full  = (pat_cnt_reg == PCW'(MAX_MATCHERS));
    assign load_elem = s_acc && (s_command == CMD_PUSH) && !elem_full;
    assign load_pat  = s_acc && (s_command == CMD_APPEND) && !pat_full;

    // top-first scan walks down from the last pushed entry
    assign top_pos    = elem_cnt_reg - ECW'(1) - p_reg;
    assign elem_raddr = bu_reg ? p_reg[EAW-1:0] : top_pos[EAW-1:0];
    assign pat_raddr  = m_reg[PAW-1:0];

    always_ff @(posedge aclk) begin
        if (load_elem) begin
            elem_mem[elem_cnt_reg[EAW-1:0]] <= s_element_id[IW-1:0];
        end
        elem_rd_reg <= elem_mem[elem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (load_pat) begin
            pat_mem[pat_cnt_reg[PAW-1:0]] <= {s_matcher_kind, s_matcher_id[IW-1:0]};
        end
        pat_rd_reg <= pat_mem[pat_raddr];
    end

    assign step_in.skip    = skip_reg;
    assign step_in.p_lt_n  = (p_reg < elem_cnt_reg);
    assign step_in.m_eq_pc = (m_reg == pat_cnt_reg);
    assign step_in.m_last  = ({1'b0, m_reg} + (PCW + 1)'(1)) == {1'b0, pat_cnt_reg};
    assign step_in.id_eq   = (pat_rd_reg[IW-1:0] == elem_rd_reg);
    assign step_in.kind    = pat_rd_reg[KIND_W+IW-1:IW];

    wsm_step u_step (
        .si (step_in),
        .so (step)
    );

    always_comb begin
        state_next    = state_reg;
        elem_cnt_next = elem_cnt_reg;
        pat_cnt_next  = pat_cnt_reg;
        ovf_next      = ovf_reg;
        p_next        = p_reg;
        m_next        = m_reg;
        skip_next     = skip_reg;
        bu_next       = bu_reg;
        res_hit_next  = res_hit_reg;
        res_err_next  = res_err_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        out_hit_next  = out_hit_reg;
        out_err_next  = out_err_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (s_command == CMD_PUSH) begin
                        if (elem_full) begin
                            ovf_next = 1'b1;
                        end else begin
                            elem_cnt_next = elem_cnt_reg + ECW'(1);
                        end
                    end else if (s_command == CMD_APPEND) begin
                        if (pat_full) begin
                            ovf_next = 1'b1;
                        end else begin
                            pat_cnt_next = pat_cnt_reg + PCW'(1);
                        end
                    end else if (s_command == CMD_EVAL) begin
                        if (ovf_reg) begin
                            res_hit_next  = 1'b0;
                            res_err_next  = ERR_OVF;
                            elem_cnt_next = '0;
                            pat_cnt_next  = '0;
                            ovf_next      = 1'b0;
                            state_next    = ST_OUT;
                        end else begin
                            bu_next    = s_bottom_up;
                            p_next     = '0;
                            m_next     = '0;
                            skip_next  = 1'b0;
                            state_next = ST_RD;
                        end
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EX;
            end
            ST_EX: begin
                if (step.done) begin
                    res_hit_next  = step.hit;
                    res_err_next  = step.err;
                    elem_cnt_next = '0;
                    pat_cnt_next  = '0;
                    ovf_next      = 1'b0;
                    state_next    = ST_OUT;
                end else begin
                    if (step.inc_p) begin
                        p_next = p_reg + ECW'(1);
                    end
                    if (step.inc_m) begin
                        m_next = m_reg + PCW'(1);
                    end
                    skip_next  = step.skip_next;
                    state_next = ST_RD;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_hit_next = res_hit_reg && (res_err_reg == ERR_NONE);
                    out_err_next = res_err_reg;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            elem_cnt_reg <= '0;
            pat_cnt_reg  <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elem_cnt_reg <= elem_cnt_next;
            pat_cnt_reg  <= pat_cnt_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        m_reg       <= m_next;
        skip_reg    <= skip_next;
        bu_reg      <= bu_next;
        res_hit_reg <= res_hit_next;
        res_err_reg <= res_err_next;
        out_hit_reg <= out_hit_next;
        out_err_reg <= out_err_next;
    end

    assign m_tvalid = m_valid_reg;
    always_comb begin
        m_tdata                       = '0;
        m_tdata[M_HIT_BIT]            = out_hit_reg;
        m_tdata[M_ERR_LSB +: ERR_W]   = out_err_reg;
    end

    // a match never carries an error code
    a_hit_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_hit_reg |-> out_err_reg == ERR_NONE)
        else $error("match reported together with an error");

    // scan pointers stay within the loaded stores
    a_ptr_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EX |-> (p_reg <= elem_cnt_reg) && (m_reg <= pat_cnt_reg))
        else $error("scan pointer past store fill");

    // stores are empty once a verdict is pending
    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT |-> elem_cnt_reg == '0 && pat_cnt_reg == '0 && !ovf_reg)
        else $error("stores not cleared after evaluation");

    // fill counts never pass the store depth
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (elem_cnt_reg <= ECW'(MAX_ELEMENTS)) && (pat_cnt_reg <= PCW'(MAX_MATCHERS)))
        else $error("fill count beyond store depth");

    // a pending result is only replaced after it was taken
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && m_valid_reg && !m_tready |=> state_reg == ST_OUT)
        else $error("result register overwritten while stalled");

endmodule

@@ sim/tb_wildcard_sequence_matcher.sv @@
// Self-checking testbench for the wildcard sequence matcher: stack/pattern loads and verdict checks.
`timescale 1ns / 1ps

module tb_wildcard_sequence_matcher import wsm_pkg::*; ();

    localparam int STACK_DEPTH   = 64;
    localparam int PATTERN_DEPTH = 16;
    localparam int RANDOM_ITEMS  = 650;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic             hit;
        logic [ERR_W-1:0] err;
    } verdict_t;

    // Shadow copy of both stores; predicts the verdict of every evaluate transaction.
    class verdict_tracker;
        logic [ID_FIELD_W-1:0] stack_ids[STACK_DEPTH];
        int unsigned           stack_len;
        logic [KIND_W-1:0]     pat_kind[PATTERN_DEPTH];
        logic [ID_FIELD_W-1:0] pat_id[PATTERN_DEPTH];
        int unsigned           pat_len;
        bit                    overflowed;
        verdict_t              pending_verdicts[$];
        int unsigned           mismatches;

        function void wipe_stores();
            stack_len  = 0;
            pat_len    = 0;
            overflowed = 1'b0;
        endfunction

        function logic [ID_FIELD_W-1:0] id_at(int unsigned pos, bit bu);
            return stack_ids[bu ? pos : stack_len - 1 - pos];
        endfunction

        // Greedy prefix match, no backtracking.
        function void scan_pattern(bit bu, output logic hit, output logic [ERR_W-1:0] err);
            int unsigned p;
            int unsigned m;
            bit          found;
            p   = 0;
            m   = 0;
            hit = 1'b0;
            err = ERR_NONE;
            while (m < pat_len) begin
                case (pat_kind[m])
                    KIND_ANY: begin
                        if (p >= stack_len) return;
                    end
                    KIND_ID: begin
                        if (p >= stack_len) return;
                        if (id_at(p, bu) != pat_id[m]) return;
                    end
                    KIND_REST: begin
                        if (m + 1 == pat_len) begin
                            hit = 1'b1;
                            return;
                        end
                        m++;
                        found = 1'b0;
                        // the matcher after REST is compared by ID unless it is ANY
                        while (!found && p < stack_len) begin
                            if (pat_kind[m] == KIND_REST) begin
                                err = ERR_REST;
                                return;
                            end
                            if (pat_kind[m] == KIND_ANY || pat_id[m] == id_at(p, bu))
                                found = 1'b1;
                            else
                                p++;
                        end
                        if (!found) return;
                    end
                    default: begin
                        err = ERR_KIND;
                        return;
                    end
                endcase
                m++;
                p++;
            end
            hit = 1'b1;
        endfunction

        function void note_transaction(logic [CMD_W-1:0] cmd, logic [ID_FIELD_W-1:0] elem,
                                       logic [KIND_W-1:0] kind, logic [ID_FIELD_W-1:0] mid,
                                       logic bu);
            verdict_t v;
            logic     h;
            case (cmd)
                CMD_PUSH: begin
                    if (stack_len < STACK_DEPTH) begin
                        stack_ids[stack_len] = elem;
                        stack_len++;
                    end else begin
                        overflowed = 1'b1;
                    end
                end
                CMD_APPEND: begin
                    if (pat_len < PATTERN_DEPTH) begin
                        pat_kind[pat_len] = kind;
                        pat_id[pat_len]   = mid;
                        pat_len++;
                    end else begin
                        overflowed = 1'b1;
                    end
                end
                CMD_EVAL: begin
                    if (overflowed) begin
                        v.hit = 1'b0;
                        v.err = ERR_OVF;
                    end else begin
                        scan_pattern(bu, h, v.err);
                        v.hit = h && (v.err == ERR_NONE);
                    end
                    pending_verdicts = {pending_verdicts, v};
                    wipe_stores();
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_verdict(logic [M_DATA_W-1:0] data);
            verdict_t v;
            if (pending_verdicts.size() == 0) begin
                report($sformatf("unexpected result transaction, tdata=%h", data));
                return;
            end
            v = pending_verdicts.pop_front();
            if (data[M_HIT_BIT] !== v.hit || data[M_ERR_LSB +: ERR_W] !== v.err)
                report($sformatf("verdict: expected matched=%0d error=%0d, got matched=%0d error=%0d",
                                 v.hit, v.err, data[M_HIT_BIT], data[M_ERR_LSB +: ERR_W]));
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = CMD_PUSH;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    verdict_tracker tracker = new();
    int unsigned    items_sent;
    bit             calm_sender;
    bit             calm_receiver;

    wildcard_sequence_matcher #(
        .MAX_ELEMENTS (STACK_DEPTH),
        .MAX_MATCHERS (PATTERN_DEPTH),
        .ID_BITS      (ID_FIELD_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [ID_FIELD_W-1:0] rnd_id();
        return ID_FIELD_W'($urandom);
    endfunction

    task automatic send_item(logic [CMD_W-1:0] cmd, logic [ID_FIELD_W-1:0] elem,
                             logic [KIND_W-1:0] kind, logic [ID_FIELD_W-1:0] mid, logic bu);
        logic [S_DATA_W-1:0] word;
        int                  gap;
        word = '0;
        word[S_ELEM_LSB +: ID_FIELD_W] = elem;
        word[S_KIND_LSB +: KIND_W]     = kind;
        word[S_MID_LSB +: ID_FIELD_W]  = mid;
        word[S_BU_BIT]                 = bu;
        gap = calm_sender ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        tracker.note_transaction(cmd, elem, kind, mid, bu);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // only drops tvalid when it has to wait, so no second drive lands in this time step
    task automatic wait_drained();
        if (tracker.pending_verdicts.size() != 0) begin
            s_tvalid <= 1'b0;
            while (tracker.pending_verdicts.size() != 0) @(posedge aclk);
        end
    endtask

    // One stack load, one pattern built mostly to fit it, then an evaluate.
    task automatic random_round(int round);
        logic [ID_FIELD_W-1:0] order[$];
        logic [KIND_W-1:0]     kinds[$];
        logic [ID_FIELD_W-1:0] mids[$];
        logic [ID_FIELD_W-1:0] id;
        int                    depth;
        int                    target;
        int                    pos;
        int                    j;
        bit                    narrow;
        bit                    bu;
        narrow      = $urandom_range(0, 4) < 3;
        bu          = $urandom_range(0, 1);
        calm_sender = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) wait_drained();

        if (round % 23 == 5)
            depth = STACK_DEPTH + $urandom_range(1, 2);
        else if ($urandom_range(0, 9) == 0)
            depth = $urandom_range(9, STACK_DEPTH);
        else
            depth = $urandom_range(0, 8);
        for (int i = 0; i < depth; i++) begin
            id = narrow ? ID_FIELD_W'($urandom_range(0, 3)) : rnd_id();
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_UNUSED, rnd_id(), KIND_W'($urandom), rnd_id(), 1'($urandom));
            send_item(CMD_PUSH, id, KIND_W'($urandom), rnd_id(), 1'($urandom));
            // keep the IDs in the order the scan will visit them
            if (bu) order = {order, id};
            else order = {id, order};
        end

        target = (round % 23 == 11) ? PATTERN_DEPTH + $urandom_range(1, 2)
                                    : $urandom_range(0, 6);
        pos = 0;
        while (kinds.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    kinds = {kinds, KIND_ANY};
                    mids  = {mids, rnd_id()};
                    pos++;
                end
                3, 4, 5: begin
                    kinds = {kinds, KIND_ID};
                    mids  = {mids, (pos < order.size() ? order[pos] : rnd_id())};
                    pos++;
                end
                6, 7: begin
                    j = pos + $urandom_range(0, 3);
                    kinds = {kinds, KIND_REST};
                    mids  = {mids, rnd_id()};
                    kinds = {kinds, KIND_ID};
                    mids  = {mids, (j < order.size() ? order[j] : rnd_id())};
                    pos = j + 1;
                end
                default: begin
                    kinds = {kinds, KIND_REST};
                    mids  = {mids, rnd_id()};
                end
            endcase
        end
        if (kinds.size() != 0 && $urandom_range(0, 3) == 0) begin
            j = $urandom_range(0, kinds.size() - 1);
            if ($urandom_range(0, 1)) kinds[j] = KIND_W'($urandom_range(0, 3));
            else mids[j] = rnd_id();
        end
        for (int i = 0; i < kinds.size(); i++)
            send_item(CMD_APPEND, rnd_id(), kinds[i], mids[i], 1'($urandom));

        send_item(CMD_EVAL, rnd_id(), KIND_W'($urandom), rnd_id(), bu);
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 4) == 0) calm_receiver = !calm_receiver;
            stall = calm_receiver ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            tracker.check_verdict(m_tdata);
        end
    end

    initial begin : stimulus
        int goal;
        int round;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty pattern against empty stack
        send_item(CMD_EVAL, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        // unused command with every bit set is dropped
        send_item(CMD_UNUSED, 16'hFFFF, KIND_BAD, 16'hFFFF, 1'b1);
        // top first: exact ID then any
        send_item(CMD_PUSH, 16'hFFFF, KIND_BAD, 16'hFFFF, 1'b1);
        send_item(CMD_PUSH, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'hFFFF, KIND_ID, 16'h0000, 1'b1);
        send_item(CMD_APPEND, 16'h0000, KIND_ANY, 16'hFFFF, 1'b0);
        send_item(CMD_EVAL, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        // bottom first
        send_item(CMD_PUSH, 16'hFFFF, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_PUSH, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'h0000, KIND_ID, 16'hFFFF, 1'b0);
        send_item(CMD_EVAL, 16'hFFFF, KIND_BAD, 16'hFFFF, 1'b1);
        // unsupported kind after REST acts as an exact matcher
        send_item(CMD_PUSH, 16'h0001, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_PUSH, 16'h0002, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_PUSH, 16'h0003, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'h0000, KIND_REST, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'h0000, KIND_BAD, 16'h0001, 1'b0);
        send_item(CMD_EVAL, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        // two RESTs with an element left: error
        send_item(CMD_PUSH, 16'h0005, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'h0000, KIND_REST, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'h0000, KIND_REST, 16'h0000, 1'b0);
        send_item(CMD_EVAL, 16'h0000, KIND_ANY, 16'h0000, 1'b1);
        // two RESTs on an empty stack: plain mismatch
        send_item(CMD_APPEND, 16'h0000, KIND_REST, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'h0000, KIND_REST, 16'h0000, 1'b0);
        send_item(CMD_APPEND, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        send_item(CMD_EVAL, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        // unsupported kind on its own
        send_item(CMD_APPEND, 16'h0000, KIND_BAD, 16'h1234, 1'b0);
        send_item(CMD_EVAL, 16'h0000, KIND_ANY, 16'h0000, 1'b0);
        wait_drained();

        goal  = items_sent + RANDOM_ITEMS;
        round = 0;
        while (items_sent < goal) begin
            random_round(round);
            round++;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
